// ===== design/ntrs_pkg.sv =====
// Package for the nearest-track request scheduler.
// Holds sizes, item and result types, codes and the sequencer state type.
// No dependencies; the other design files import it, apart from ntrs_ram.
`default_nettype none

package ntrs_pkg;

    localparam int SLOTS      = 16;
    localparam int TRACK_BITS = 16;
    localparam int TOTAL_BITS = 32;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);

    typedef logic [TRACK_BITS-1:0] t_track;
    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [TOTAL_BITS-1:0] t_total;

    localparam t_track HEAD_RESET  = t_track'(50);
    localparam t_track START_RESET = t_track'(50);

    // Operation codes; the fourth code is ignored.
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_SERVE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        t_track     request_track;
    } t_item;

    typedef struct packed {
        logic [1:0] status;
        t_track     served_track;
        t_track     seek_distance;
        t_total     total_seek;
        t_count     pending_count;
    } t_result;

    // Commands from the sequencer to the slot table.
    typedef struct packed {
        logic  add;
        logic  remove;
        logic  clear;
        t_slot slot;
        t_slot rm_age;
    } t_tbl_cmd;

    // Status from the slot table to the sequencer.
    typedef struct packed {
        logic   full;
        t_slot  free_slot;
        t_count count;
    } t_tbl_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_SERVE,
        S_CLEAR,
        S_NOP
    } t_state;

endpackage

`default_nettype wire

// ===== design/nearest_track_request_scheduler_core.sv =====
// Top level of the nearest-track (shortest seek first) request scheduler.
// Depends on ntrs_pkg, ntrs_ram, ntrs_dist_unit and ntrs_slot_table.
`default_nettype none

// Usage: drive an item on i_item and raise start; the item is taken at the
// rising edge where start is high and busy is low. Each item gives exactly
// one result on o_result, shown for one cycle with o_result_valid high; the
// receiver cannot stall it, so capture it in that cycle. Add, clear and the
// ignored op code pass through one work state before the next accept. A serve
// walks all SLOTS table entries through one distance comparator, one slot a
// cycle, each compared from the registered read of the track RAM, then writes
// back before the next accept. The result strobe comes in the cycle in which
// busy drops. Write start_track through i_cfg_we / i_cfg_wdata only while the
// block is idle; it is used by the next clear item. There is no clearing pass
// after reset.
module nearest_track_request_scheduler_core import ntrs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  t_track  i_cfg_wdata,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_result_valid,
    output t_result o_result
);

    // Sequencer and working registers
    t_state             r_state, n_state;
    t_track             r_req, n_req;
    t_track             r_start;
    t_track             r_head, n_head;
    t_total             r_total, n_total;
    logic [CNT_W-1:0]   r_idx, n_idx;

    // Scan registers: nearest so far (newest among ties) and the oldest
    logic   r_found, n_found;
    t_track r_best, n_best;
    t_slot  r_pick, n_pick;
    t_track r_pick_track, n_pick_track;
    t_slot  r_pick_age, n_pick_age;
    t_slot  r_old_slot, n_old_slot;
    t_track r_old_dist, n_old_dist;
    t_track r_old_track, n_old_track;

    t_result r_result, n_result;
    logic    r_res_vld, n_res_vld;

    // Slot table, RAM and shared distance unit
    t_tbl_cmd  tbl_cmd;
    t_tbl_stat tbl_stat;
    t_slot     cmp_slot;
    logic      cmp_valid;
    t_slot     cmp_age;
    logic      ram_we;
    t_slot     ram_waddr;
    t_track    ram_rdata;
    t_track    seek_gap;
    logic      dist_lt;
    logic      dist_eq;
    t_count    cnt_m1;
    logic      use_old;
    logic [TOTAL_BITS:0] sum;
    t_total    total_sat;

    // Compare stage works on the slot read in the cycle before
    assign cmp_slot = t_slot'(r_idx - t_count'(1));
    assign cnt_m1   = tbl_stat.count - t_count'(1);
    assign use_old  = (r_old_dist == r_best);
    assign sum      = {1'b0, r_total} + (TOTAL_BITS + 1)'(r_best);
    assign total_sat = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];

    ntrs_slot_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (tbl_cmd),
        .i_rd_idx   (cmp_slot),
        .o_stat     (tbl_stat),
        .o_rd_valid (cmp_valid),
        .o_rd_age   (cmp_age)
    );

    ntrs_ram #(
        .WIDTH (TRACK_BITS),
        .DEPTH (SLOTS)
    ) u_tracks (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_req),
        .i_raddr (r_idx[SLOT_W-1:0]),
        .o_rdata (ram_rdata)
    );

    ntrs_dist_unit u_dist (
        .i_head  (r_head),
        .i_track (ram_rdata),
        .i_best  (r_best),
        .o_dist  (seek_gap),
        .o_lt    (dist_lt),
        .o_eq    (dist_eq)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_item.op)
                        OP_ADD:   n_state = S_ADD;
                        OP_SERVE: n_state = S_SCAN;
                        OP_CLEAR: n_state = S_CLEAR;
                        default:  n_state = S_NOP;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx == CNT_W'(SLOTS)) begin
                    n_state = S_SERVE;
                end
            end
            S_ADD, S_SERVE, S_CLEAR, S_NOP: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and control outputs
    always_comb begin
        n_req        = r_req;
        n_head       = r_head;
        n_total      = r_total;
        n_idx        = r_idx;
        n_found      = r_found;
        n_best       = r_best;
        n_pick       = r_pick;
        n_pick_track = r_pick_track;
        n_pick_age   = r_pick_age;
        n_old_slot   = r_old_slot;
        n_old_dist   = r_old_dist;
        n_old_track  = r_old_track;
        n_result     = r_result;
        n_res_vld    = 1'b0;
        tbl_cmd      = '0;
        ram_we       = 1'b0;
        ram_waddr    = tbl_stat.free_slot;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_item.request_track;
                    n_idx   = '0;
                    n_found = 1'b0;
                end
            end
            S_ADD: begin
                n_res_vld              = 1'b1;
                n_result.served_track  = r_head;
                n_result.seek_distance = '0;
                n_result.total_seek    = r_total;
                if (tbl_stat.full) begin
                    // drop the request
                    n_result.status        = STAT_FULL;
                    n_result.pending_count = tbl_stat.count;
                end else begin
                    ram_we                 = 1'b1;
                    tbl_cmd.add            = 1'b1;
                    tbl_cmd.slot           = tbl_stat.free_slot;
                    n_result.status        = STAT_DONE;
                    n_result.pending_count = tbl_stat.count + t_count'(1);
                end
            end
            S_SCAN: begin
                n_idx = r_idx + t_count'(1);
                if ((r_idx != '0) && cmp_valid) begin
                    n_found = 1'b1;
                    if (!r_found || dist_lt) begin
                        n_best       = seek_gap;
                        n_pick       = cmp_slot;
                        n_pick_track = ram_rdata;
                        n_pick_age   = cmp_age;
                    end else if (dist_eq && (cmp_age < r_pick_age)) begin
                        n_pick       = cmp_slot;
                        n_pick_track = ram_rdata;
                        n_pick_age   = cmp_age;
                    end
                    if (cmp_age == cnt_m1[SLOT_W-1:0]) begin
                        n_old_slot  = cmp_slot;
                        n_old_dist  = seek_gap;
                        n_old_track = ram_rdata;
                    end
                end
            end
            S_SERVE: begin
                n_res_vld = 1'b1;
                if (!r_found) begin
                    n_result.status        = STAT_EMPTY;
                    n_result.served_track  = r_head;
                    n_result.seek_distance = '0;
                    n_result.total_seek    = r_total;
                    n_result.pending_count = tbl_stat.count;
                end else begin
                    // oldest wins a tie it is part of, else newest nearest
                    tbl_cmd.remove         = 1'b1;
                    tbl_cmd.slot           = use_old ? r_old_slot : r_pick;
                    tbl_cmd.rm_age         = use_old ? cnt_m1[SLOT_W-1:0] : r_pick_age;
                    n_head                 = use_old ? r_old_track : r_pick_track;
                    n_total                = total_sat;
                    n_result.status        = STAT_DONE;
                    n_result.served_track  = n_head;
                    n_result.seek_distance = r_best;
                    n_result.total_seek    = total_sat;
                    n_result.pending_count = cnt_m1;
                end
            end
            S_CLEAR: begin
                tbl_cmd.clear          = 1'b1;
                n_total                = '0;
                n_head                 = r_start;
                n_res_vld              = 1'b1;
                n_result.status        = STAT_DONE;
                n_result.served_track  = r_start;
                n_result.seek_distance = '0;
                n_result.total_seek    = '0;
                n_result.pending_count = '0;
            end
            S_NOP: begin
                n_res_vld              = 1'b1;
                n_result.status        = STAT_DONE;
                n_result.served_track  = r_head;
                n_result.seek_distance = '0;
                n_result.total_seek    = r_total;
                n_result.pending_count = tbl_stat.count;
            end
            default: begin
                n_res_vld = 1'b0;
            end
        endcase
    end

    // Control state and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_res_vld <= 1'b0;
            r_head    <= HEAD_RESET;
            r_total   <= '0;
            r_start   <= START_RESET;
        end else begin
            r_state   <= n_state;
            r_res_vld <= n_res_vld;
            r_head    <= n_head;
            r_total   <= n_total;
            if (i_cfg_we) begin
                r_start <= i_cfg_wdata;
            end
        end
    end

    // Payload and scan registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_best       <= n_best;
        r_pick       <= n_pick;
        r_pick_track <= n_pick_track;
        r_pick_age   <= n_pick_age;
        r_old_slot   <= n_old_slot;
        r_old_dist   <= n_old_dist;
        r_old_track  <= n_old_track;
        r_result     <= n_result;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_vld;
    assign o_result       = r_result;

endmodule

`default_nettype wire

// ===== design/ntrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module ntrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/ntrs_dist_unit.sv =====
// Shared seek-distance unit: absolute track difference and compare to best.
// Depends on ntrs_pkg.
`default_nettype none

module ntrs_dist_unit import ntrs_pkg::*; (
    input  t_track i_head,
    input  t_track i_track,
    input  t_track i_best,
    output t_track o_dist,
    output logic   o_lt,
    output logic   o_eq
);

    assign o_dist = (i_head > i_track) ? (i_head - i_track) : (i_track - i_head);
    assign o_lt   = (o_dist < i_best);
    assign o_eq   = (o_dist == i_best);

endmodule

`default_nettype wire

// ===== design/ntrs_slot_table.sv =====
// Slot table: valid bits, request ages and pending count for every slot.
// Depends on ntrs_pkg.
`default_nettype none

module ntrs_slot_table import ntrs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tbl_cmd  i_cmd,
    input  t_slot     i_rd_idx,
    output t_tbl_stat o_stat,
    output logic      o_rd_valid,
    output t_slot     o_rd_age
);

    logic   r_valid [SLOTS];
    t_slot  r_age   [SLOTS];
    t_count r_count;

    // Lowest free slot.
    always_comb begin
        o_stat.full      = 1'b1;
        o_stat.free_slot = '0;
        o_stat.count     = r_count;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                o_stat.full      = 1'b0;
                o_stat.free_slot = t_slot'(i);
            end
        end
    end

    assign o_rd_valid   = r_valid[i_rd_idx];
    assign o_rd_age     = r_age[i_rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_valid[i] <= 1'b0;
                r_age[i]   <= '0;
            end
            r_count <= '0;
        end else if (i_cmd.add) begin
            // age every pending request, new one is the newest
            for (int i = 0; i < SLOTS; i++) begin
                if (r_valid[i]) begin
                    r_age[i] <= r_age[i] + t_slot'(1);
                end
            end
            r_valid[i_cmd.slot] <= 1'b1;
            r_age[i_cmd.slot]   <= '0;
            r_count             <= r_count + t_count'(1);
        end else if (i_cmd.remove) begin
            // close the gap left by the removed age
            for (int i = 0; i < SLOTS; i++) begin
                if (r_valid[i] && (r_age[i] > i_cmd.rm_age)) begin
                    r_age[i] <= r_age[i] - t_slot'(1);
                end
            end
            r_valid[i_cmd.slot] <= 1'b0;
            r_age[i_cmd.slot]   <= '0;
            r_count             <= r_count - t_count'(1);
        end
    end

endmodule

`default_nettype wire

// ===== design/ntrs_checker.sv =====
// Port-level checker for the nearest-track request scheduler, bound to the top.
// Depends on ntrs_pkg and nearest_track_request_scheduler_core.
`default_nettype none

module ntrs_checker import ntrs_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_result_valid,
    input t_result o_result
);

    // An accepted item makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // A result is shown only once the block has finished its item.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // Status is one of the defined codes and the count fits the table.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ((o_result.status == STAT_DONE ||
                             o_result.status == STAT_EMPTY ||
                             o_result.status == STAT_FULL) &&
                            (o_result.pending_count <= t_count'(SLOTS))))
        else $error("bad status or pending count");

    // An empty serve moves nothing and leaves nothing pending.
    a_empty_serve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status == STAT_EMPTY)) |->
            ((o_result.seek_distance == '0) && (o_result.pending_count == '0)))
        else $error("empty serve reported movement or pending items");

    // A full table reports exactly SLOTS pending requests.
    a_full_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status == STAT_FULL)) |->
            (o_result.pending_count == t_count'(SLOTS)))
        else $error("full status with free slots");

endmodule

bind nearest_track_request_scheduler_core ntrs_checker u_ntrs_checker (.*);

`default_nettype wire

// ===== verif/ntrs_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the nearest-track request scheduler: keeps its own copy of the
// request table, predicts the result of every accepted item and checks each strobed result.
// Depends on ntrs_pkg.
module ntrs_scoreboard import ntrs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  t_track  i_cfg_wdata,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_item   i_item,
    input  logic    i_result_valid,
    input  t_result i_result,
    output int      o_fail_count,
    output int      o_pending
);

    t_track  track_tbl [SLOTS];
    logic    slot_used [SLOTS];
    int      slot_rank [SLOTS];    // 0 = newest pending request
    t_track  head_track;
    t_total  seek_sum;
    t_track  restart_track;
    t_result due_results [$];
    int      fails = 0;

    function automatic t_track track_gap(input t_track a, input t_track b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            fails++;
        end
    endtask

    task automatic schedule_item(input t_item it, output t_result res);
        int                  slot;
        int                  oldest;
        int                  pick;
        int                  gone_rank;
        int                  n;
        logic                found;
        t_track              best;
        t_track              d;
        logic [TOTAL_BITS:0] sum;
        res    = '0;
        slot   = -1;
        oldest = -1;
        pick   = -1;
        found  = 1'b0;
        best   = '0;
        res.status = STAT_DONE;
        case (it.op)
            OP_ADD: begin
                for (int i = 0; i < SLOTS; i++)
                    if (!slot_used[i] && slot < 0) slot = i;
                if (slot < 0) begin
                    res.status = STAT_FULL;
                end else begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_used[i]) slot_rank[i]++;
                    track_tbl[slot] = it.request_track;
                    slot_used[slot] = 1'b1;
                    slot_rank[slot] = 0;
                end
            end
            OP_SERVE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i]) begin
                        d = track_gap(head_track, track_tbl[i]);
                        if (!found || d < best) best = d;
                        found = 1'b1;
                        if (oldest < 0 || slot_rank[i] > slot_rank[oldest]) oldest = i;
                    end
                end
                if (!found) begin
                    res.status = STAT_EMPTY;
                end else begin
                    // Oldest wins a tie; otherwise the newest of the nearest.
                    if (track_gap(head_track, track_tbl[oldest]) == best) begin
                        pick = oldest;
                    end else begin
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_used[i] && track_gap(head_track, track_tbl[i]) == best
                                && (pick < 0 || slot_rank[i] < slot_rank[pick]))
                                pick = i;
                    end
                    gone_rank       = slot_rank[pick];
                    slot_used[pick] = 1'b0;
                    slot_rank[pick] = 0;
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_used[i] && slot_rank[i] > gone_rank) slot_rank[i]--;
                    res.seek_distance = best;
                    head_track        = track_tbl[pick];
                    sum = {1'b0, seek_sum} + (TOTAL_BITS + 1)'(best);
                    seek_sum = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    slot_used[i] = 1'b0;
                    slot_rank[i] = 0;
                end
                seek_sum   = '0;
                head_track = restart_track;
            end
            default: ;
        endcase
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i]) n++;
        res.served_track  = head_track;
        res.total_seek    = seek_sum;
        res.pending_count = t_count'(n);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                track_tbl[i] = '0;
                slot_used[i] = 1'b0;
                slot_rank[i] = 0;
            end
            head_track    = HEAD_RESET;
            restart_track = START_RESET;
            seek_sum      = '0;
            due_results.delete();
        end else begin
            if (i_result_valid) begin
                if (due_results.size() == 0) begin
                    $display("%0t ns: result with none expected, got %p", $time, i_result);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    check_field("status", 32'(want.status), 32'(i_result.status));
                    check_field("served_track", 32'(want.served_track),
                                32'(i_result.served_track));
                    check_field("seek_distance", 32'(want.seek_distance),
                                32'(i_result.seek_distance));
                    check_field("total_seek", want.total_seek, i_result.total_seek);
                    check_field("pending_count", 32'(want.pending_count),
                                32'(i_result.pending_count));
                end
            end
            if (i_start && !i_busy) begin
                schedule_item(i_item, want);
                due_results.push_back(want);
            end
            if (i_cfg_we) restart_track = i_cfg_wdata;
        end
        o_pending    <= due_results.size();
        o_fail_count <= fails;
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the nearest-track request scheduler: clock, reset, directed
// and random item streams, start_track writes and the final verdict.
// Depends on ntrs_pkg, the scheduler core and ntrs_scoreboard.
module tb_top;
    import ntrs_pkg::*;

    localparam int         LIMIT       = 500_000;
    localparam int         PHASE_ITEMS = 500;
    localparam int         GAP_CAP     = 12;
    localparam logic [1:0] OP_IGNORED  = 2'd3;

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_cfg_we    = 1'b0;
    t_track  i_cfg_wdata = '0;
    logic    start       = 1'b0;
    t_item   i_item      = '0;
    logic    busy;
    logic    o_result_valid;
    t_result o_result;

    int      fail_count;
    int      pending;
    int      cycles   = 0;
    int      idle_pct = 0;     // chance in a hundred of lengthening the idle stretch after an item
    int      add_pct  = 50;    // share of adds among adds and serves in the current burst
    t_track  window_base = '0; // lower edge of the narrow track window that makes ties likely

    always #5 i_clk = ~i_clk;

    nearest_track_request_scheduler_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .i_item         (i_item),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    ntrs_scoreboard u_scoreboard (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (i_item),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Watchdog: end the run if the block hangs or results go missing.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Present one item and hold it until the block takes it, then leave the
    // line idle for a random stretch when the phase asks for it. Keep start
    // high across back-to-back items so it is never dropped and raised in one step.
    task automatic send_item(input logic [1:0] op, input t_track trk);
        int gap;
        gap = 0;
        start  <= 1'b1;
        i_item <= {op, trk};
        do @(posedge i_clk); while (busy);
        while (idle_pct > 0 && gap < GAP_CAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start  <= 1'b0;
            i_item <= t_item'($urandom);   // junk on the bus while start is low
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop start and wait until every result is in and the block is idle.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    // Write start_track; only call with the block drained.
    task automatic write_start(input t_track value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 3) return OP_CLEAR;
        if (r < 6) return OP_IGNORED;
        if (r < 6 + (add_pct * 94) / 100) return OP_ADD;
        return OP_SERVE;
    endfunction

    // Half the tracks in a narrow window (ties, short seeks), else anything or an end track.
    function automatic t_track pick_track();
        int r;
        r = $urandom_range(9);
        if (r < 4) return t_track'(window_base + $urandom_range(15));
        if (r < 8) return t_track'($urandom);
        if (r == 8) return $urandom_range(1) ? '1 : '0;
        return window_base;
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty serve and the unused op at the reset head, then a
        // clear with start_track still at its reset value.
        send_item(OP_SERVE, '0);
        send_item(OP_IGNORED, '1);
        send_item(OP_CLEAR, '0);
        drain();
        write_start(16'd100);
        send_item(OP_CLEAR, '0);
        send_item(OP_ADD, 16'd90);
        send_item(OP_ADD, 16'd110);
        send_item(OP_ADD, 16'd120);
        send_item(OP_SERVE, '0);        // 90 and 110 tie; oldest (90) is among them
        send_item(OP_ADD, 16'd80);
        send_item(OP_ADD, 16'd100);
        send_item(OP_SERVE, '0);        // 80 and 100 tie; oldest is 110, so newest wins
        send_item(OP_ADD, '0);
        send_item(OP_ADD, '1);
        for (int k = 0; k < 11; k++) send_item(OP_ADD, t_track'($urandom));
        send_item(OP_ADD, 16'h1234);    // table full: drop and report

        // Bounce the head between the two end tracks, a full-stroke seek per
        // serve, then serve the empty table.
        drain();
        write_start('0);
        send_item(OP_CLEAR, '0);
        for (int k = 0; k < 8; k++) begin
            send_item(OP_ADD, '1);
            send_item(OP_SERVE, '0);
            send_item(OP_ADD, '0);
            send_item(OP_SERVE, '0);
        end
        send_item(OP_SERVE, '0);
        send_item(OP_CLEAR, '0);

        // Random phases: no idling, heavy sender idling, no idling again
        // (the receiver cannot stall), light sender idling. Each phase loads a
        // new start track, extremes first, and opens with a clear to use it.
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0:       write_start('0);
                1:       write_start('1);
                2:       write_start(t_track'($urandom));
                default: write_start(16'h8000);
            endcase
            idle_pct = (ph == 1) ? 65 : (ph == 3) ? 35 : 0;
            send_item(OP_CLEAR, t_track'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Switch bursts between filling, balanced and draining the table.
                if (n % 20 == 0) begin
                    case ($urandom_range(2))
                        0:       add_pct = 85;
                        1:       add_pct = 50;
                        default: add_pct = 15;
                    endcase
                    window_base = t_track'($urandom);
                end
                send_item(pick_op(), pick_track());
            end
        end

        idle_pct = 0;
        drain();
        repeat (25) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
